// ===== rtl/fbfl_pkg.sv =====
// Shared types and constants for the fixed-block free-list pool.
package fbfl_pkg;

   localparam int POOL_DEPTH = 1024;
   localparam int SLOT_W     = 10;
   localparam int CNT_W      = 11;
   localparam int LINK_W     = SLOT_W + 1;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(POOL_DEPTH);

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOMEM = 2'd1,
      ST_INVAL = 2'd2
   } status_type;

   typedef struct packed {
      logic accept;
      logic pop_finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pop_hit;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== rtl/fbfl_req_if.sv =====
// Request channel interface: operation and slot to release.
interface fbfl_req_if;
   import fbfl_pkg::*;

   logic              valid;
   logic              ready;
   op_type            op;
   logic [SLOT_W-1:0] slot_to_free;

   modport source (output valid, output op, output slot_to_free, input ready);
   modport sink   (input valid, input op, input slot_to_free, output ready);
endinterface

// ===== rtl/fbfl_rsp_if.sv =====
// Response channel interface: status, granted slot and live slot count.
interface fbfl_rsp_if;
   import fbfl_pkg::*;

   logic              valid;
   logic              ready;
   status_type        status;
   logic [SLOT_W-1:0] granted_slot;
   logic [CNT_W-1:0]  live_slots;

   modport source (output valid, output status, output granted_slot, output live_slots,
                   input ready);
   modport sink   (input valid, input status, input granted_slot, input live_slots,
                   output ready);
endinterface

// ===== rtl/fixed_block_free_list_pool_core.sv =====
// Top level of the fixed-block free-list pool allocator.
// The pool hands out slot indices from a free list kept as links in an internal
// RAM, falling back to never-used slots. Each request transaction yields exactly
// one response transaction. An allocate from the free list waits in the pop state
// for the next head, read from the synchronous link RAM; any other request loads
// its response on accept. A new request is taken while a finished response is being
// handed over. No clearing pass is needed after reset. The capacity register
// must be written by the user only while idle; the block does not enforce it.
module fixed_block_free_list_pool_core (
   input  logic                         clock,
   input  logic                         reset,
   fbfl_req_if.sink                     req_chan,
   fbfl_rsp_if.source                   rsp_chan,
   input  logic                         csr_we,
   input  logic [fbfl_pkg::CNT_W-1:0]   csr_wdata
);
   import fbfl_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   fbfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbfl_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_op      (req_chan.op),
      .req_slot    (req_chan.slot_to_free),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_status  (rsp_chan.status),
      .rsp_granted (rsp_chan.granted_slot),
      .rsp_live    (rsp_chan.live_slots)
   );

endmodule

// ===== rtl/fbfl_ram.sv =====
// Generic single-port RAM with registered read data.
module fbfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/fbfl_ctrl.sv =====
// Controller state machine that sequences accepts and free-list pops.
module fbfl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fbfl_pkg::dp_stat_type stat,
   output fbfl_pkg::ctrl_cmd_type cmd
);
   import fbfl_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_POP  = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.accept     = 1'b0;
      cmd.pop_finish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = stat.out_free;
            cmd.accept = req_valid && stat.out_free;
            if (cmd.accept && stat.pop_hit) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            cmd.pop_finish = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/fbfl_dp.sv =====
// Datapath: pool counters, free-list head, link memory and response register.
module fbfl_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  fbfl_pkg::ctrl_cmd_type        cmd,
   output fbfl_pkg::dp_stat_type         stat,
   input  fbfl_pkg::op_type              req_op,
   input  logic [fbfl_pkg::SLOT_W-1:0]   req_slot,
   input  logic                          csr_we,
   input  logic [fbfl_pkg::CNT_W-1:0]    csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fbfl_pkg::status_type          rsp_status,
   output logic [fbfl_pkg::SLOT_W-1:0]   rsp_granted,
   output logic [fbfl_pkg::CNT_W-1:0]    rsp_live
);
   import fbfl_pkg::*;

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic              head_valid_ff, head_valid_in;
   logic [CNT_W-1:0]  high_water_ff, high_water_in;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [SLOT_W-1:0] out_granted_ff, out_granted_in;
   logic [CNT_W-1:0]  out_live_ff, out_live_in;

   logic [CNT_W-1:0]  eff_cap;
   logic              full;
   logic              load;
   logic              ram_we;
   logic [SLOT_W-1:0] ram_addr;
   logic [LINK_W-1:0] ram_wdata;
   logic [LINK_W-1:0] ram_rdata;

   fbfl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (POOL_DEPTH)
   ) u_link_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign eff_cap = (cap_ff > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : cap_ff;
   assign full    = (live_ff >= eff_cap);

   assign stat.pop_hit  = (req_op == OP_ALLOC) && !full && head_valid_ff;
   assign stat.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      cap_in         = csr_we ? csr_wdata : cap_ff;
      head_in        = head_ff;
      head_valid_in  = head_valid_ff;
      high_water_in  = high_water_ff;
      live_in        = live_ff;
      out_status_in  = out_status_ff;
      out_granted_in = out_granted_ff;
      out_live_in    = out_live_ff;
      load           = 1'b0;
      ram_we         = 1'b0;
      ram_addr       = head_ff;
      ram_wdata      = {head_valid_ff, head_ff};

      if (cmd.accept) begin
         if (req_op == OP_ALLOC) begin
            if (full) begin
               load           = 1'b1;
               out_status_in  = ST_NOMEM;
               out_granted_in = '0;
               out_live_in    = live_ff;
            end else if (!head_valid_ff) begin
               load           = 1'b1;
               high_water_in  = high_water_ff + 1'b1;
               live_in        = live_ff + 1'b1;
               out_status_in  = ST_OK;
               out_granted_in = high_water_ff[SLOT_W-1:0];
               out_live_in    = live_ff + 1'b1;
            end
         end else begin
            load           = 1'b1;
            out_granted_in = '0;
            if (({1'b0, req_slot} >= eff_cap) || (live_ff == '0)) begin
               out_status_in = ST_INVAL;
               out_live_in   = live_ff;
            end else begin
               ram_we        = 1'b1;
               ram_addr      = req_slot;
               head_in       = req_slot;
               head_valid_in = 1'b1;
               live_in       = live_ff - 1'b1;
               out_status_in = ST_OK;
               out_live_in   = live_ff - 1'b1;
            end
         end
      end

      if (cmd.pop_finish) begin
         load           = 1'b1;
         head_in        = ram_rdata[SLOT_W-1:0];
         head_valid_in  = ram_rdata[SLOT_W];
         live_in        = live_ff + 1'b1;
         out_status_in  = ST_OK;
         out_granted_in = head_ff;
         out_live_in    = live_ff + 1'b1;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_RESET;
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         high_water_ff <= '0;
         live_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         high_water_ff <= high_water_in;
         live_ff       <= live_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff  <= out_status_in;
      out_granted_ff <= out_granted_in;
      out_live_ff    <= out_live_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_granted = out_granted_ff;
   assign rsp_live    = out_live_ff;

endmodule

// ===== tb/sv/tb_fixed_block_free_list_pool_core.sv =====
// Self-checking testbench for the fixed-block free-list pool allocator core.
module tb_fixed_block_free_list_pool_core;
   import fbfl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int LONG_HOLD_AFTER = 140;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 47;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] slot;
   } pool_request;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] granted_slot;
      logic [CNT_W-1:0]  live_slots;
   } pool_reply;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [CNT_W-1:0]  csr_wdata;

   fbfl_req_if req_chan ();
   fbfl_rsp_if rsp_chan ();

   fixed_block_free_list_pool_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the pool state.
   logic [CNT_W-1:0]  capacity = CAP_RESET;
   logic [SLOT_W-1:0] head = '0;
   logic              head_valid = 1'b0;
   logic [CNT_W-1:0]  high_water = '0;
   logic [CNT_W-1:0]  live_count = '0;
   bit   [SLOT_W-1:0] link_to [POOL_DEPTH];
   bit                link_ok [POOL_DEPTH];

   pool_request pending[$];
   pool_reply   expected_q[$];

   int  errors = 0;
   int  req_accepted = 0;
   int  rsp_checked = 0;
   int  ok_count = 0;
   int  nomem_count = 0;
   int  inval_count = 0;
   int  settings_used = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  cycle_count = 0;
   bit  long_hold_done = 1'b0;
   bit  quiet = 1'b0;

   function automatic pool_reply pool_apply(input op_type op, input logic [SLOT_W-1:0] slot);
      pool_reply        r;
      logic [CNT_W-1:0] cap_eff;
      cap_eff = (capacity > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : capacity;
      r.status = ST_OK;
      r.granted_slot = '0;
      if (op == OP_ALLOC) begin
         if (live_count >= cap_eff) begin
            r.status = ST_NOMEM;
         end else if (head_valid) begin
            r.granted_slot = head;
            head_valid = link_ok[head];
            head = link_to[head];
            live_count = live_count + 1'b1;
         end else begin
            r.granted_slot = high_water[SLOT_W-1:0];
            high_water = high_water + 1'b1;
            live_count = live_count + 1'b1;
         end
      end else begin
         if ({1'b0, slot} >= cap_eff || live_count == '0) begin
            r.status = ST_INVAL;
         end else begin
            link_to[slot] = head;
            link_ok[slot] = head_valid;
            head = slot;
            head_valid = 1'b1;
            live_count = live_count - 1'b1;
         end
      end
      r.live_slots = live_count;
      return r;
   endfunction

   always @(posedge clock) begin : drive_requests
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_q.push_back(pool_apply(req_chan.op, req_chan.slot_to_free));
            req_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending.size() != 0) begin
               pool_request next_req;
               next_req = pending.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.op <= next_req.op;
               req_chan.slot_to_free <= next_req.slot;
               if (!quiet && $urandom_range(0, 4) == 0) begin
                  gap_left = $urandom_range(1, 13);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_responses
      pool_reply want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response: status %0d slot %0d live %0d", $time,
                        rsp_chan.status, rsp_chan.granted_slot, rsp_chan.live_slots);
               errors++;
            end else begin
               want = expected_q.pop_front();
               rsp_checked++;
               if (rsp_chan.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                           want.status, rsp_chan.status);
                  errors++;
               end
               if (rsp_chan.granted_slot !== want.granted_slot) begin
                  $display("%0t: granted_slot mismatch: expected %0d, actual %0d", $time,
                           want.granted_slot, rsp_chan.granted_slot);
                  errors++;
               end
               if (rsp_chan.live_slots !== want.live_slots) begin
                  $display("%0t: live_slots mismatch: expected %0d, actual %0d", $time,
                           want.live_slots, rsp_chan.live_slots);
                  errors++;
               end
               case (want.status)
                  ST_OK:    ok_count++;
                  ST_NOMEM: nomem_count++;
                  default:  inval_count++;
               endcase
            end
         end
         // Hold the response side off long enough for the core to back up its input.
         if (!long_hold_done && req_accepted >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding", $time,
                  cycle_count, expected_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending.size() != 0 || req_chan.valid || expected_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      capacity = value;
      settings_used++;
      @(negedge clock);
   endtask

   task automatic queue_alloc();
      pending.push_back('{OP_ALLOC, SLOT_W'($urandom)});
   endtask

   task automatic queue_free(input logic [SLOT_W-1:0] slot);
      pending.push_back('{OP_FREE, slot});
   endtask

   initial begin : stimulus
      int               cap_eff;
      int               run_len;
      bit               filling;
      logic [CNT_W-1:0] phase_cap;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.op = OP_ALLOC;
      req_chan.slot_to_free = '0;
      rsp_chan.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A free into an empty pool, bump allocation, reuse from the list,
      // a double free and a stray free of the top slot.
      queue_free(10'd5);
      repeat (3) queue_alloc();
      queue_free(10'd1);
      queue_free(10'd0);
      repeat (2) queue_alloc();
      queue_free(10'd2);
      queue_free(10'd2);
      queue_free(10'd1023);
      queue_free(10'd7);

      // With the capacity lowered, the top slot is still granted from the list.
      write_capacity(11'd2);
      repeat (3) queue_alloc();
      queue_free(10'd3);
      queue_free(10'd1023);
      queue_free(10'd1);

      write_capacity(11'd2047);
      repeat (3) queue_alloc();

      write_capacity(11'd0);
      queue_alloc();
      queue_free(10'd0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            2:       phase_cap = CAP_RESET;
            4:       phase_cap = 11'd1;
            default: phase_cap = CNT_W'($urandom_range(2, 12));
         endcase
         write_capacity(phase_cap);
         if (phase == RANDOM_PHASES - 1) begin
            quiet = 1'b1;
         end
         cap_eff = (phase_cap > CNT_W'(POOL_DEPTH)) ? POOL_DEPTH : int'(phase_cap);
         run_len = (cap_eff > 20) ? 12 : cap_eff + 3;
         filling = 1'b0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % run_len == 0) begin
               filling = !filling;
            end
            if ($urandom_range(0, 99) < (filling ? 80 : 20)) begin
               queue_alloc();
            end else if ($urandom_range(0, 9) == 0) begin
               queue_free(SLOT_W'($urandom));
            end else begin
               queue_free(SLOT_W'($urandom_range(0, cap_eff - 1)));
            end
         end
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (expected_q.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, expected_q.size());
         errors++;
      end
      $display("Checked %0d of %0d request transactions over %0d capacity writes.",
               rsp_checked, req_accepted, settings_used);
      $display("Outcomes: %0d success, %0d out of memory, %0d invalid argument; %0d errors.",
               ok_count, nomem_count, inval_count, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== fixed_block_free_list_pool_core.f =====
rtl/fbfl_pkg.sv
rtl/fbfl_req_if.sv
rtl/fbfl_rsp_if.sv
rtl/fbfl_ram.sv
rtl/fbfl_ctrl.sv
rtl/fbfl_dp.sv
rtl/fixed_block_free_list_pool_core.sv
tb/sv/tb_fixed_block_free_list_pool_core.sv
